[design/swap_slot_table_assert.svh]
// Assertion macros shared by the swap slot table RTL.
`ifndef SWAP_SLOT_TABLE_ASSERT_SVH
`define SWAP_SLOT_TABLE_ASSERT_SVH
`ifndef SYNTH
`define SST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SST_ASSERT_SAME(label, ante, cons, msg)
`define SST_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[design/sst_pkg.sv]
// Shared types and codes of the swap slot table.
package sst_pkg;

    localparam int PAGE_SHIFT = 12;

    typedef enum logic [1:0] {
        OP_SWAP_OUT  = 2'd0,
        OP_SWAP_IN   = 2'd1,
        OP_LOOK_PAGE = 2'd2,
        OP_LOOK_FRAME = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_RANGE    = 3'd1,
        STS_FULL     = 3'd2,
        STS_MISS     = 3'd3,
        STS_XFER_BAD = 3'd4
    } status_t;

    localparam logic REG_FRAME_BASE = 1'b0;
    localparam logic REG_SWAP_BASE  = 1'b1;

endpackage

[design/sst_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
module sst_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/swap_slot_table.sv]
// Swap slot table top level: sequencer around the slot and frame memories.
// Flow from acceptance to result valid: a bad slot or address ends the transaction without a scan,
// lookup by frame and already-swapped swap out finish after one frame memory read; swap out scans
// slot memory, lookup by page likewise, and swap in scans frame memory. One transaction is in
// flight at a time; the next is accepted once the result goes valid. After reset a clearing pass
// runs over both memories before the first transaction is taken.
module swap_slot_table
    import sst_pkg::*;
#(
    parameter int SLOT_COUNT  = 4096,
    parameter int FRAME_COUNT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [46:0] cfg_wdata,
    // input transaction
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [47:0] virt_addr,
    input  logic [47:0] phys_addr,
    input  logic [15:0] slot_in,
    input  logic        transfer_ok,
    // result transaction
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [11:0] slot_out,
    output logic        already_out,
    output logic [47:0] block_addr,
    output logic [47:0] frame_addr,
    output logic [12:0] live_count
);

`include "swap_slot_table_assert.svh"

    localparam int SW  = $clog2(SLOT_COUNT);
    localparam int FW  = $clog2(FRAME_COUNT);
    localparam int PW  = $clog2(SLOT_COUNT + 1);   // slot number plus one
    localparam int CW  = ((SW > FW) ? SW : FW) + 1;
    localparam int EW  = 37;                        // used bit and page number
    localparam logic [CW-1:0] SLOT_LIM  = CW'(SLOT_COUNT);
    localparam logic [CW-1:0] FRAME_LIM = CW'(FRAME_COUNT);
    localparam logic [CW-1:0] CLR_LIM   =
        CW'((SLOT_COUNT > FRAME_COUNT) ? SLOT_COUNT : FRAME_COUNT);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_PREP   = 10'b0000000100,
        ST_RANGE  = 10'b0000001000,
        ST_FREAD  = 10'b0000010000,
        ST_SSCAN  = 10'b0000100000,
        ST_SREAD  = 10'b0001000000,
        ST_FSCAN  = 10'b0010000000,
        ST_COMMIT = 10'b0100000000,
        ST_FINISH = 10'b1000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [46:0]     frame_base_reg, swap_base_reg;
    op_t             op_reg, op_next;
    logic [35:0]     page_reg, page_next;
    logic [47:0]     phys_reg, phys_next;
    logic [15:0]     slot_in_reg, slot_in_next;
    logic            ok_reg, ok_next;
    logic [48:0]     diff_reg, diff_next;
    logic [FW-1:0]   fi_reg, fi_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [FW-1:0]   owner_reg, owner_next;
    logic            slot_hit_reg, slot_hit_next;
    logic            frame_hit_reg, frame_hit_next;
    logic            already_reg, already_next;
    status_t         sts_reg, sts_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pend_reg, pend_next;
    logic [CW-1:0]   ridx_reg, ridx_next;
    logic [12:0]     count_reg, count_next;

    logic            out_valid_reg;
    logic [2:0]      status_reg;
    logic [11:0]     slot_out_reg;
    logic            already_out_reg;
    logic [47:0]     block_reg, frame_addr_reg;
    logic [12:0]     live_reg;

    // memory ports
    logic            s_we, f_we;
    logic [SW-1:0]   s_waddr, s_raddr;
    logic [FW-1:0]   f_waddr, f_raddr;
    logic [EW-1:0]   s_wdata, s_rdata;
    logic [PW-1:0]   f_wdata, f_rdata;

    logic            accept, out_free, scan_hit;
    logic [CW-1:0]   scan_lim;
    logic [PW-1:0]   f_dec, want;

    sst_ram #(.DEPTH(SLOT_COUNT), .WIDTH(EW)) u_slot_mem (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    sst_ram #(.DEPTH(FRAME_COUNT), .WIDTH(PW)) u_frame_mem (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign f_dec    = f_rdata - PW'(1);
    assign want     = PW'(slot_in_reg[SW-1:0]) + PW'(1);
    assign scan_lim = (state_reg == ST_SSCAN) ? SLOT_LIM : FRAME_LIM;

    // Scan match: free slot for swap out, page hit for page lookup, owner for swap in.
    always_comb
    begin
        if (state_reg == ST_FSCAN)
        begin
            scan_hit = (f_rdata == want);
        end
        else if (op_reg == OP_SWAP_OUT)
        begin
            scan_hit = !s_rdata[EW-1];
        end
        else
        begin
            scan_hit = s_rdata[EW-1] && (s_rdata[35:0] == page_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        page_next      = page_reg;
        phys_next      = phys_reg;
        slot_in_next   = slot_in_reg;
        ok_next        = ok_reg;
        diff_next      = diff_reg;
        fi_next        = fi_reg;
        slot_next      = slot_reg;
        owner_next     = owner_reg;
        slot_hit_next  = slot_hit_reg;
        frame_hit_next = frame_hit_reg;
        already_next   = already_reg;
        sts_next       = sts_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        ridx_next      = ridx_reg;
        count_next     = count_reg;
        s_we           = 1'b0;
        s_waddr        = slot_reg;
        s_wdata        = '0;
        s_raddr        = slot_in_reg[SW-1:0];
        f_we           = 1'b0;
        f_waddr        = fi_reg;
        f_wdata        = '0;
        f_raddr        = fi_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep both memories to the free / unswapped state
                s_we     = (cnt_reg < SLOT_LIM);
                s_waddr  = cnt_reg[SW-1:0];
                f_we     = (cnt_reg < FRAME_LIM);
                f_waddr  = cnt_reg[FW-1:0];
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CLR_LIM - CW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = op_t'(op);
                    page_next      = virt_addr[47:PAGE_SHIFT];
                    phys_next      = phys_addr;
                    slot_in_next   = slot_in;
                    ok_next        = transfer_ok;
                    slot_hit_next  = 1'b0;
                    frame_hit_next = 1'b0;
                    already_next   = 1'b0;
                    sts_next       = STS_OK;
                    cnt_next       = '0;
                    pend_next      = 1'b0;
                    state_next     = ST_PREP;
                end
            end
            ST_PREP:
            begin
                diff_next = {1'b0, phys_reg} - {2'b00, frame_base_reg};
                unique case (op_reg)
                    OP_SWAP_IN:
                    begin
                        if (slot_in_reg < 16'(SLOT_COUNT))
                        begin
                            state_next = ST_SREAD;
                        end
                        else
                        begin
                            sts_next   = STS_MISS;
                            state_next = ST_FINISH;
                        end
                    end
                    OP_LOOK_PAGE:
                    begin
                        state_next = ST_SSCAN;
                    end
                    default:
                    begin
                        state_next = ST_RANGE;
                    end
                endcase
            end
            ST_RANGE:
            begin
                if (diff_reg[48] || !(diff_reg[47:PAGE_SHIFT] < 36'(FRAME_COUNT)))
                begin
                    sts_next   = STS_RANGE;
                    state_next = ST_FINISH;
                end
                else
                begin
                    fi_next    = diff_reg[PAGE_SHIFT +: FW];
                    f_raddr    = diff_reg[PAGE_SHIFT +: FW];
                    state_next = ST_FREAD;
                end
            end
            ST_FREAD:
            begin
                if (f_rdata != '0)
                begin
                    slot_next     = f_dec[SW-1:0];
                    slot_hit_next = 1'b1;
                    already_next  = (op_reg == OP_SWAP_OUT);
                    state_next    = ST_FINISH;
                end
                else if (op_reg == OP_LOOK_FRAME)
                begin
                    sts_next   = STS_MISS;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SSCAN;
                end
            end
            ST_SREAD:
            begin
                if (!s_rdata[EW-1])
                begin
                    sts_next   = STS_MISS;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_FSCAN;
                end
            end
            ST_SSCAN, ST_FSCAN:
            begin
                // one read issued per cycle, its data checked in the next cycle
                s_raddr = cnt_reg[SW-1:0];
                f_raddr = cnt_reg[FW-1:0];
                if (pend_reg && scan_hit)
                begin
                    pend_next = 1'b0;
                    if (state_reg == ST_FSCAN)
                    begin
                        owner_next     = ridx_reg[FW-1:0];
                        slot_next      = slot_in_reg[SW-1:0];
                        frame_hit_next = 1'b1;
                    end
                    else
                    begin
                        slot_next = ridx_reg[SW-1:0];
                    end
                    slot_hit_next = 1'b1;
                    if (op_reg == OP_LOOK_PAGE)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (!ok_reg)
                    begin
                        sts_next   = STS_XFER_BAD;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
                else if (pend_reg && (cnt_reg == scan_lim))
                begin
                    pend_next  = 1'b0;
                    sts_next   = (op_reg == OP_SWAP_OUT) ? STS_FULL : STS_MISS;
                    state_next = ST_FINISH;
                end
                else
                begin
                    pend_next = (cnt_reg < scan_lim);
                    ridx_next = cnt_reg;
                    if (cnt_reg < scan_lim)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            ST_COMMIT:
            begin
                s_we    = 1'b1;
                s_waddr = slot_reg;
                f_we    = 1'b1;
                if (op_reg == OP_SWAP_OUT)
                begin
                    s_wdata    = {1'b1, page_reg};
                    f_waddr    = fi_reg;
                    f_wdata    = PW'(slot_reg) + PW'(1);
                    count_next = count_reg + 13'd1;
                end
                else
                begin
                    s_wdata = '0;
                    f_waddr = owner_reg;
                    f_wdata = '0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 13'd1;
                    end
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            count_reg      <= '0;
            frame_base_reg <= '0;
            swap_base_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_BASE: frame_base_reg <= cfg_wdata;
                    REG_SWAP_BASE:  swap_base_reg  <= cfg_wdata;
                    default:        frame_base_reg <= frame_base_reg;
                endcase
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // transaction payload and result registers: no reset needed
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        page_reg      <= page_next;
        phys_reg      <= phys_next;
        slot_in_reg   <= slot_in_next;
        ok_reg        <= ok_next;
        diff_reg      <= diff_next;
        fi_reg        <= fi_next;
        slot_reg      <= slot_next;
        owner_reg     <= owner_next;
        slot_hit_reg  <= slot_hit_next;
        frame_hit_reg <= frame_hit_next;
        already_reg   <= already_next;
        sts_reg       <= sts_next;
        ridx_reg      <= ridx_next;
        if ((state_reg == ST_FINISH) && out_free)
        begin
            status_reg      <= sts_reg;
            slot_out_reg    <= slot_hit_reg ? 12'(slot_reg) : 12'd0;
            already_out_reg <= already_reg;
            block_reg       <= slot_hit_reg ? (48'(swap_base_reg) + 48'(slot_reg)) : 48'd0;
            frame_addr_reg  <= frame_hit_reg ?
                               (48'(frame_base_reg) + 48'({owner_reg, 12'd0})) : 48'd0;
            live_reg        <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_out    = slot_out_reg;
    assign already_out = already_out_reg;
    assign block_addr  = block_reg;
    assign frame_addr  = frame_addr_reg;
    assign live_count  = live_reg;

    `SST_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= 13'(SLOT_COUNT), "live count overflow")
    `SST_ASSERT_NEXT(a_one_in_flight, accept, !in_ready, "second transaction taken early")
    `SST_ASSERT_NEXT(a_commit_inc, (state_reg == ST_COMMIT) && (op_reg == OP_SWAP_OUT),
                     count_reg == $past(count_reg) + 13'd1, "swap out did not count slot")

endmodule

[sim/tb_swap_slot_table.sv]
// Self-checking swap slot table testbench: directed and random traffic against a behavioral predictor.
module tb_swap_slot_table;
    import sst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 4096;
    localparam int FRAMES       = 4096;
    localparam int PAGE_BYTES   = 4096;
    localparam int RAND_ITEMS   = 1750;
    localparam int IDLE_LIMIT   = 40000;  // clear pass + full scan + long hold, several times over
    localparam int HOLD_CYCLES  = 600;
    localparam logic [46:0] BASE_MAX = {47{1'b1}};

    typedef struct packed {
        op_t         op;
        logic [47:0] virt;
        logic [47:0] phys;
        logic [15:0] slot;
        logic        ok;
    } swap_req_t;

    typedef struct packed {
        status_t     sts;
        logic [11:0] slot;
        logic        already;
        logic [47:0] blk;
        logic [47:0] frm;
        logic [12:0] live;
    } swap_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [46:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [47:0] virt_addr;
    logic [47:0] phys_addr;
    logic [15:0] slot_in;
    logic        transfer_ok;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [11:0] slot_out;
    logic        already_out;
    logic [47:0] block_addr;
    logic [47:0] frame_addr;
    logic [12:0] live_count;

    swap_slot_table i_dut (.*);

    // Predictor state: a mirror of the slot and frame tables plus the two base registers
    logic        slot_busy [SLOTS];
    logic [12:0] frame_owner_p1 [FRAMES];   // slot + 1 owned by the frame, 0 when none
    logic [35:0] slot_vpn [SLOTS];
    logic [12:0] slots_in_use;
    logic [46:0] frame_base;
    logic [46:0] swap_base;

    swap_req_t pending_txns [$];
    swap_rsp_t expected_rsps [$];
    swap_req_t offered;
    bit        failed;
    int        rsps_seen;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Map a physical address to a managed frame index, -1 when outside the managed window.
    function automatic int frame_of(logic [47:0] phys);
        logic [47:0] delta;
        begin
            if (phys < {1'b0, frame_base})
                return -1;
            delta = phys - {1'b0, frame_base};
            if ((delta >> PAGE_SHIFT) >= FRAMES)
                return -1;
            return int'(delta >> PAGE_SHIFT);
        end
    endfunction

    // Apply one accepted transaction to the mirror and queue the response it must produce.
    task automatic predict_swap_table(input swap_req_t t);
        swap_rsp_t r;
        int        fi;
        int        owner;
        int        free_slot;
        logic [35:0] vpn;
        begin
            r = '0;
            r.sts = STS_OK;
            vpn = t.virt[47:12];
            case (t.op)
                OP_SWAP_OUT:
                begin
                    fi = frame_of(t.phys);
                    if (fi < 0)
                        r.sts = STS_RANGE;
                    else if (frame_owner_p1[fi] != 0)
                    begin
                        r.slot    = 12'(frame_owner_p1[fi] - 1);
                        r.already = 1'b1;
                        r.blk     = {1'b0, swap_base} + 48'(frame_owner_p1[fi] - 1);
                    end
                    else
                    begin
                        free_slot = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (free_slot < 0 && !slot_busy[i])
                                free_slot = i;
                        if (free_slot < 0)
                            r.sts = STS_FULL;
                        else
                        begin
                            r.slot = 12'(free_slot);
                            r.blk  = {1'b0, swap_base} + 48'(free_slot);
                            if (!t.ok)
                                r.sts = STS_XFER_BAD;
                            else
                            begin
                                slot_busy[free_slot] = 1'b1;
                                frame_owner_p1[fi]   = 13'(free_slot + 1);
                                slot_vpn[free_slot]  = vpn;
                                slots_in_use++;
                            end
                        end
                    end
                end
                OP_SWAP_IN:
                begin
                    owner = -1;
                    if (t.slot < SLOTS && slot_busy[t.slot])
                        for (int i = 0; i < FRAMES; i++)
                            if (owner < 0 && frame_owner_p1[i] == 13'(t.slot + 1))
                                owner = i;
                    if (owner < 0)
                        r.sts = STS_MISS;
                    else
                    begin
                        r.slot = t.slot[11:0];
                        r.blk  = {1'b0, swap_base} + 48'(t.slot);
                        r.frm  = {1'b0, frame_base} + 48'(owner) * PAGE_BYTES;
                        if (!t.ok)
                            r.sts = STS_XFER_BAD;
                        else
                        begin
                            slot_busy[t.slot]     = 1'b0;
                            frame_owner_p1[owner] = '0;
                            slot_vpn[t.slot]      = '0;
                            if (slots_in_use > 0)
                                slots_in_use--;
                        end
                    end
                end
                OP_LOOK_PAGE:
                begin
                    r.sts = STS_MISS;
                    for (int i = 0; i < SLOTS; i++)
                        if (r.sts == STS_MISS && slot_busy[i] && slot_vpn[i] == vpn)
                        begin
                            r.sts  = STS_OK;
                            r.slot = 12'(i);
                            r.blk  = {1'b0, swap_base} + 48'(i);
                        end
                end
                default:
                begin
                    fi = frame_of(t.phys);
                    if (fi < 0)
                        r.sts = STS_RANGE;
                    else if (frame_owner_p1[fi] == 0)
                        r.sts = STS_MISS;
                    else
                    begin
                        r.slot = 12'(frame_owner_p1[fi] - 1);
                        r.blk  = {1'b0, swap_base} + 48'(frame_owner_p1[fi] - 1);
                    end
                end
            endcase
            r.live = slots_in_use;
            expected_rsps.push_back(r);
        end
    endtask

    // Physical address of a managed frame with random byte offset inside the page.
    function automatic logic [47:0] frame_phys(int idx);
        return {1'b0, frame_base} + 48'(idx) * PAGE_BYTES + 48'($urandom_range(0, 4095));
    endfunction

    function automatic logic [47:0] rand48();
        return {$urandom(), $urandom()};
    endfunction

    // Virtual address drawn from a small page pool so that page lookups hit often.
    function automatic logic [47:0] pooled_virt();
        logic [35:0] vpn;
        begin
            vpn = 36'($urandom_range(0, 40));
            if ($urandom_range(0, 9) == 0)
                vpn = 36'(rand48());
            return {vpn, 12'($urandom_range(0, 4095))};
        end
    endfunction

    function automatic swap_req_t make_req(op_t o, logic [47:0] v, logic [47:0] p,
                                           logic [15:0] s, logic ok);
        swap_req_t t;
        begin
            t.op = o;
            t.virt = v;
            t.phys = p;
            t.slot = s;
            t.ok = ok;
            return t;
        end
    endfunction

    // Mostly well-formed traffic on a small working set of frames and slots,
    // with out-of-range addresses, far frames and fully random noise mixed in.
    function automatic swap_req_t random_req();
        swap_req_t t;
        int        pick;
        int        fidx;
        logic [47:0] p;
        begin
            pick = $urandom_range(0, 99);
            fidx = ($urandom_range(0, 19) == 0) ? $urandom_range(0, FRAMES - 1)
                                                : $urandom_range(0, 47);
            p = frame_phys(fidx);
            case ($urandom_range(0, 9))
                0: p = {1'b0, frame_base} + 48'(FRAMES) * PAGE_BYTES + 48'($urandom_range(0, 1 << 20));
                1: if (frame_base != 0)
                       p = {1'b0, frame_base} - 48'($urandom_range(1, 1 << 20));
                default: ;
            endcase
            if (pick < 40)
                t = make_req(OP_SWAP_OUT, pooled_virt(), p, 16'($urandom()),
                             $urandom_range(0, 7) != 0);
            else if (pick < 70)
                t = make_req(OP_SWAP_IN, rand48(), rand48(),
                             16'($urandom_range(0, slots_in_use + 8)),
                             $urandom_range(0, 5) != 0);
            else if (pick < 82)
                t = make_req(OP_LOOK_PAGE, pooled_virt(), rand48(), 16'($urandom()),
                             1'($urandom()));
            else if (pick < 94)
                t = make_req(OP_LOOK_FRAME, rand48(), p, 16'($urandom()), 1'($urandom()));
            else
                t = make_req(op_t'($urandom_range(0, 3)), rand48(), rand48(),
                             16'($urandom()), 1'($urandom()));
            return t;
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            op          <= '0;
            virt_addr   <= '0;
            phys_addr   <= '0;
            slot_in     <= '0;
            transfer_ok <= 1'b0;
            burst_left  = 0;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_swap_table(offered);
            // advance only when nothing is held or the held transaction just went through
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_txns.size() > 0)
                begin
                    offered = pending_txns.pop_front();
                    op          <= offered.op;
                    virt_addr   <= offered.virt;
                    phys_addr   <= offered.phys;
                    slot_in     <= offered.slot;
                    transfer_ok <= offered.ok;
                    in_valid    <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready pattern redrawn among three stall modes; one long hold-off forces
    // the block to back up and stall its input while the sender keeps offering.
    int stall_mode;
    int mode_cycles;
    int hold_left;
    bit hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_mode  = 0;
            mode_cycles = 0;
            hold_left   = 0;
            hold_done   = 1'b0;
            rsps_seen   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                rsps_seen++;
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response: status %0d slot %0d", status, slot_out);
                    failed = 1'b1;
                end
                else
                begin
                    swap_rsp_t e;
                    e = expected_rsps.pop_front();
                    if (status !== e.sts)
                    begin
                        $error("status: expected %0d, got %0d", e.sts, status);
                        failed = 1'b1;
                    end
                    if (slot_out !== e.slot)
                    begin
                        $error("slot_out: expected %0d, got %0d", e.slot, slot_out);
                        failed = 1'b1;
                    end
                    if (already_out !== e.already)
                    begin
                        $error("already_out: expected %0d, got %0d", e.already, already_out);
                        failed = 1'b1;
                    end
                    if (block_addr !== e.blk)
                    begin
                        $error("block_addr: expected %h, got %h", e.blk, block_addr);
                        failed = 1'b1;
                    end
                    if (frame_addr !== e.frm)
                    begin
                        $error("frame_addr: expected %h, got %h", e.frm, frame_addr);
                        failed = 1'b1;
                    end
                    if (live_count !== e.live)
                    begin
                        $error("live_count: expected %0d, got %0d", e.live, live_count);
                        failed = 1'b1;
                    end
                end
                if (rsps_seen == 300 && !hold_done)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (mode_cycles == 0)
            begin
                stall_mode  = $urandom_range(0, 2);
                mode_cycles = 64;
            end
            mode_cycles--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom());
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    // Watchdog: count cycles with neither an accepted transaction nor a taken response.
    int idle_cycles;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles++;
    end

    // Hold until all queued transactions have been sent and answered.
    task automatic drain_phase();
        begin
            while (pending_txns.size() > 0 || in_valid || expected_rsps.size() > 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    task automatic write_bases(input logic [46:0] fb, input logic [46:0] sb);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= REG_FRAME_BASE;
            cfg_wdata <= fb;
            @(posedge clk);
            cfg_index <= REG_SWAP_BASE;
            cfg_wdata <= sb;
            @(posedge clk);
            cfg_we    <= 1'b0;
            frame_base = fb;
            swap_base  = sb;
        end
    endtask

    initial
    begin
        logic [46:0] fb_set [4];
        logic [46:0] sb_set [4];

        failed       = 1'b0;
        slots_in_use = '0;
        frame_base   = '0;
        swap_base    = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_vpn[i]  = '0;
        end
        for (int i = 0; i < FRAMES; i++)
            frame_owner_p1[i] = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_FRAME_BASE;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: first frame and last frame, repeats, range edges, failed transfers, bad slots
        write_bases(47'h0000_1000_0000, 47'h0000_0012_3456);
        pending_txns.push_back(make_req(OP_SWAP_OUT, 48'h0000_0000_1abc, frame_phys(0), '0, 1'b1));
        pending_txns.push_back(make_req(OP_SWAP_OUT, 48'h0000_0000_2000, frame_phys(0), '1, 1'b0));
        pending_txns.push_back(make_req(OP_SWAP_OUT, 48'h0000_0000_3000, frame_phys(4095), '0, 1'b0));
        pending_txns.push_back(make_req(OP_SWAP_OUT, 48'h0000_0000_3000, frame_phys(4095), '0, 1'b1));
        pending_txns.push_back(make_req(OP_SWAP_OUT, '0, 48'h0000_0fff_ffff, '0, 1'b1));
        pending_txns.push_back(make_req(OP_SWAP_OUT, '0, 48'h0000_1000_0000 + 48'(FRAMES) * PAGE_BYTES,
                                        '0, 1'b1));
        pending_txns.push_back(make_req(OP_SWAP_OUT, '1, frame_phys(5), '0, 1'b1));
        pending_txns.push_back(make_req(OP_LOOK_PAGE, 48'h0000_0000_3fff, '0, '0, 1'b0));
        pending_txns.push_back(make_req(OP_LOOK_PAGE, '1, '1, '1, 1'b1));
        pending_txns.push_back(make_req(OP_LOOK_PAGE, 48'h0000_0009_9000, '0, '0, 1'b1));
        pending_txns.push_back(make_req(OP_LOOK_FRAME, '0, frame_phys(4095), '0, 1'b0));
        pending_txns.push_back(make_req(OP_LOOK_FRAME, '0, frame_phys(7), '0, 1'b1));
        pending_txns.push_back(make_req(OP_LOOK_FRAME, '0, '1, '0, 1'b1));
        pending_txns.push_back(make_req(OP_SWAP_IN, '1, '1, 16'd1, 1'b0));
        pending_txns.push_back(make_req(OP_SWAP_IN, '0, '0, 16'd1, 1'b1));
        pending_txns.push_back(make_req(OP_SWAP_IN, '0, '0, 16'd1, 1'b1));
        pending_txns.push_back(make_req(OP_SWAP_IN, '0, '0, 16'hffff, 1'b1));
        pending_txns.push_back(make_req(OP_SWAP_IN, '0, '0, 16'd4096, 1'b1));
        pending_txns.push_back(make_req(OP_SWAP_IN, '0, '0, 16'd4095, 1'b1));
        pending_txns.push_back(make_req(OP_SWAP_OUT, 48'h0000_0000_3000, frame_phys(4095), '0, 1'b1));
        drain_phase();

        // Random phases across base settings, extremes included
        fb_set[0] = '0;
        sb_set[0] = '0;
        fb_set[1] = BASE_MAX;
        sb_set[1] = BASE_MAX;
        fb_set[2] = 47'({$urandom(), $urandom()});
        sb_set[2] = 47'({$urandom(), $urandom()});
        fb_set[3] = 47'($urandom());
        sb_set[3] = BASE_MAX - 47'($urandom_range(0, 4095));
        for (int ph = 0; ph < 4; ph++)
        begin
            write_bases(fb_set[ph], sb_set[ph]);
            for (int n = 0; n < RAND_ITEMS / 4; n++)
                pending_txns.push_back(random_req());
            drain_phase();
        end

        repeat (20) @(posedge clk);
        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
